>>> hw/rtl/rain_tip_window_tracker_defines.svh
// Assertion macros for the rain tip window tracker.
`ifndef RAIN_TIP_WINDOW_TRACKER_DEFINES_SVH
`define RAIN_TIP_WINDOW_TRACKER_DEFINES_SVH
`ifndef SYNTH
`define RTW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rtw assertion failed");
`define RTW_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rtw assertion failed");
`else
`define RTW_ASSERT(lbl, prop)
`define RTW_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> hw/rtl/rtw_pkg.sv
`timescale 1ns / 1ps
package rtw_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int TS_W          = 64;
    localparam int DSR_W         = 41;

    typedef struct packed {
        logic            vld;
        logic [TS_W-1:0] ts;
    } cell_t;

    typedef struct packed {
        logic clr;
        logic push;
        logic rot;
    } cell_ctrl_t;

    typedef struct packed {
        logic             start;
        logic [TS_W-1:0]  dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [TS_W-1:0]  quotient;
        logic [DSR_W-1:0] remainder;
    } div_rsp_t;

endpackage

>>> hw/rtl/rtw_cell.sv
`timescale 1ns / 1ps
module rtw_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  rtw_pkg::cell_ctrl_t ctrl,
    input  rtw_pkg::cell_t     prev_in,
    input  rtw_pkg::cell_t     next_in,
    output rtw_pkg::cell_t     q
);

    logic                     vld_reg;
    logic [rtw_pkg::TS_W-1:0] ts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.push)
        begin
            vld_reg <= prev_in.vld;
        end
        else if (ctrl.rot)
        begin
            vld_reg <= next_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            ts_reg <= prev_in.ts;
        end
        else if (ctrl.rot)
        begin
            ts_reg <= next_in.ts;
        end
    end

    assign q.vld = vld_reg;
    assign q.ts  = ts_reg;

endmodule

>>> hw/rtl/rtw_div.sv
`timescale 1ns / 1ps
module rtw_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtw_pkg::div_req_t req,
    output rtw_pkg::div_rsp_t rsp
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [5:0]                cnt_reg;
    logic [rtw_pkg::TS_W-1:0]  dvd_reg;
    logic [rtw_pkg::DSR_W-1:0] dsr_reg;
    logic [rtw_pkg::DSR_W-1:0] rem_reg;
    logic [rtw_pkg::DSR_W:0]   shifted;
    logic                      fits;

    assign shifted = {rem_reg, dvd_reg[rtw_pkg::TS_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd63;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit a cycle while busy, shifted in behind the dividend
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[rtw_pkg::TS_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= rtw_pkg::DSR_W'(shifted - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= shifted[rtw_pkg::DSR_W-1:0];
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> hw/rtl/rain_tip_window_tracker.sv
`timescale 1ns / 1ps
// Channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall  | req_type, now_us
// out      | output    | out_valid / out_stall| accepted .. rate_x100
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A result is published once the 16-step walk round the history cell ring is done and, where
// needed, a run of the 64-step serial divider (day roll remainder, rate) has finished. The input
// stalls from acceptance until the result is published.
// A new item is taken while the last result still waits.
// Reset clears the sequencer, day state, divider control and the history valid bits at once; a
// stalled result holds the sequencer in its final state until taken.
`include "rain_tip_window_tracker_defines.svh"
module rain_tip_window_tracker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [63:0] now_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [7:0]  tips_in_window,
    output logic [31:0] accumulated_tips,
    output logic [31:0] interval_ms,
    output logic        interval_valid,
    output logic [31:0] rate_x100,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_RATE_WIN = 2'd1;
    localparam logic [1:0] REG_DAY_WIN  = 2'd2;
    localparam logic [1:0] REG_TIP_AMT  = 2'd3;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROLL  = 4'd1;
    localparam logic [3:0] S_ROLLW = 4'd2;
    localparam logic [3:0] S_TIP   = 4'd3;
    localparam logic [3:0] S_TIPW  = 4'd4;
    localparam logic [3:0] S_CNT   = 4'd5;
    localparam logic [3:0] S_RATE0 = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_MUL2  = 4'd8;
    localparam logic [3:0] S_DIV2  = 4'd9;
    localparam logic [3:0] S_RATEW = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_MS1   = 4'd12;

    localparam int DEPTH = rtw_pkg::HISTORY_DEPTH;

    // ceil(2^46 / 125): delta / 1000 = ((delta >> 3) * MS_RECIP) >> 46 below the limit
    localparam logic [39:0] MS_RECIP   = 40'd562949953422;
    localparam logic [63:0] MS_SAT_LIM = 64'd4294967296000;

    logic [31:0] debounce_reg;
    logic [31:0] rate_win_reg;
    logic [39:0] day_win_reg;
    logic [15:0] tip_amt_reg;

    logic [3:0]  state_reg;
    logic        req_reg;
    logic [63:0] now_reg;
    logic [63:0] day_start_reg;
    logic [63:0] last_tip_reg;
    logic [31:0] daily_reg;
    logic [31:0] interval_reg;
    logic        known_reg;
    logic        acc_reg;
    logic [4:0]  tips_reg;
    logic        stop_reg;
    logic [3:0]  step_reg;
    logic [63:0] prod_reg;
    logic [31:0] rate_reg;
    logic        ms_big_reg;
    logic [38:0] ms_y_reg;
    logic [38:0] pp_hh_reg;
    logic [38:0] pp_hl_reg;
    logic [39:0] pp_lh_reg;
    logic [39:0] pp_ll_reg;

    logic        out_valid_reg;
    logic        o_acc_reg;
    logic [7:0]  o_tips_reg;
    logic [31:0] o_daily_reg;
    logic [31:0] o_int_reg;
    logic        o_known_reg;
    logic [31:0] o_rate_reg;

    rtw_pkg::cell_t      cells [DEPTH];
    rtw_pkg::cell_t      head_in;
    rtw_pkg::cell_ctrl_t cctrl;
    rtw_pkg::div_req_t   dreq;
    rtw_pkg::div_rsp_t   drsp;

    logic [39:0] win;
    logic [63:0] elapsed;
    logic [63:0] delta;
    logic [64:0] age;
    logic [34:0] num_known;
    logic [31:0] q_sat;
    logic [79:0] ms_sum;
    logic        tip_ok;
    logic        in_acc;
    logic        out_take;
    logic        fin_go;
    logic [DEPTH-1:0] vld_vec;

    assign win      = (day_win_reg == 40'd0) ? 40'd1 : day_win_reg;
    assign elapsed  = now_reg - day_start_reg;
    assign delta    = now_reg - last_tip_reg;
    assign age      = {1'b0, now_reg} - {1'b0, cells[0].ts};
    assign num_known = 35'(tip_amt_reg * 19'd360000);
    assign q_sat    = (|drsp.quotient[63:32]) ? 32'hFFFF_FFFF : drsp.quotient[31:0];
    assign ms_sum   = {1'b0, pp_hh_reg, 40'd0} + {21'd0, pp_hl_reg, 20'd0}
                    + {20'd0, pp_lh_reg, 20'd0} + {40'd0, pp_ll_reg};
    assign tip_ok   = !req_reg && (last_tip_reg != 64'd0) && (delta >= {32'd0, debounce_reg});
    assign in_acc   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign fin_go   = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    assign in_stall = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;

    assign head_in.vld = 1'b1;
    assign head_in.ts  = now_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            rtw_pkg::cell_t prev_c;
            rtw_pkg::cell_t next_c;
            assign prev_c = (g == 0) ? head_in : cells[(g + DEPTH - 1) % DEPTH];
            assign next_c = cells[(g + 1) % DEPTH];
            assign vld_vec[g] = cells[g].vld;
            rtw_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cctrl),
                .prev_in (prev_c),
                .next_in (next_c),
                .q       (cells[g])
            );
        end
    endgenerate

    rtw_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Cell ring and divider control
    always_comb
    begin
        cctrl.clr     = (state_reg == S_ROLLW) && drsp.done;
        cctrl.rot     = state_reg == S_CNT;
        cctrl.push    = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = {24'd0, elapsed[39:0]};
        dreq.divisor  = {1'b0, win};
        case (state_reg)
            S_ROLL:
            begin
                dreq.dividend = elapsed;
                dreq.start    = (day_start_reg != 64'd0) && (elapsed >= {24'd0, win});
            end
            S_TIP:
            begin
                if (!req_reg && (last_tip_reg == 64'd0))
                begin
                    cctrl.push = 1'b1;
                end
            end
            S_TIPW:
            begin
                cctrl.push = 1'b1;
            end
            S_RATE0:
            begin
                dreq.dividend = 64'({num_known, 1'b0}) + {32'd0, interval_reg};
                dreq.divisor  = {8'd0, interval_reg, 1'b0};
                dreq.start    = (tips_reg != 5'd0) && known_reg && (interval_reg != 32'd0);
            end
            S_DIV2:
            begin
                dreq.dividend = {prod_reg[62:0], 1'b0} + {32'd0, rate_win_reg};
                dreq.divisor  = {8'd0, rate_win_reg, 1'b0};
                dreq.start    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= 32'd10000;
            rate_win_reg <= 32'd600000000;
            day_win_reg  <= 40'd86400000000;
            tip_amt_reg  <= 16'd279;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data[31:0];
                REG_RATE_WIN: rate_win_reg <= cfg_data[31:0];
                REG_DAY_WIN:  day_win_reg  <= cfg_data;
                REG_TIP_AMT:  tip_amt_reg  <= cfg_data[15:0];
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            day_start_reg <= '0;
            last_tip_reg  <= '0;
            daily_reg     <= '0;
            interval_reg  <= '0;
            known_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cctrl.push)
            begin
                last_tip_reg <= now_reg;
                daily_reg    <= daily_reg + 32'd1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= S_ROLL;
                    end
                end
                S_ROLL:
                begin
                    if (day_start_reg == 64'd0)
                    begin
                        day_start_reg <= now_reg;
                        state_reg     <= S_TIP;
                    end
                    else if (dreq.start)
                    begin
                        state_reg <= S_ROLLW;
                    end
                    else
                    begin
                        state_reg <= S_TIP;
                    end
                end
                S_ROLLW:
                begin
                    if (drsp.done)
                    begin
                        day_start_reg <= now_reg - {23'd0, drsp.remainder};
                        last_tip_reg  <= '0;
                        daily_reg     <= '0;
                        interval_reg  <= '0;
                        known_reg     <= 1'b0;
                        state_reg     <= S_TIP;
                    end
                end
                S_TIP:
                begin
                    if (cctrl.push)
                    begin
                        interval_reg <= '0;
                        known_reg    <= 1'b0;
                    end
                    state_reg <= tip_ok ? S_MS1 : S_CNT;
                end
                S_MS1:   state_reg <= S_TIPW;
                S_TIPW:
                begin
                    interval_reg <= ms_big_reg ? 32'hFFFF_FFFF : ms_sum[77:46];
                    known_reg    <= 1'b1;
                    state_reg    <= S_CNT;
                end
                S_CNT:
                begin
                    if (step_reg == 4'(DEPTH - 1))
                    begin
                        state_reg <= S_RATE0;
                    end
                end
                S_RATE0:
                begin
                    if (tips_reg == 5'd0)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (dreq.start)
                    begin
                        state_reg <= S_RATEW;
                    end
                    else if (rate_win_reg != 32'd0)
                    begin
                        state_reg <= S_MUL1;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_DIV2;
                S_DIV2:  state_reg <= S_RATEW;
                S_RATEW:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers of the item in flight and of the held result
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= req_type;
            now_reg <= now_us;
        end
        case (state_reg)
            S_TIP:
            begin
                acc_reg    <= cctrl.push;
                tips_reg   <= '0;
                stop_reg   <= 1'b0;
                step_reg   <= '0;
                rate_reg   <= '0;
                ms_big_reg <= delta >= MS_SAT_LIM;
                ms_y_reg   <= delta[41:3];
            end
            S_MS1:
            begin
                pp_hh_reg <= ms_y_reg[38:20] * MS_RECIP[39:20];
                pp_hl_reg <= ms_y_reg[38:20] * MS_RECIP[19:0];
                pp_lh_reg <= ms_y_reg[19:0] * MS_RECIP[39:20];
                pp_ll_reg <= ms_y_reg[19:0] * MS_RECIP[19:0];
            end
            S_TIPW:
            begin
                acc_reg <= 1'b1;
            end
            S_CNT:
            begin
                step_reg <= step_reg + 4'd1;
                // Skip entries later than now; stop at the first one too old
                if (cells[0].vld && !stop_reg && !age[64])
                begin
                    if (age[63:0] <= {32'd0, rate_win_reg})
                    begin
                        tips_reg <= tips_reg + 5'd1;
                    end
                    else
                    begin
                        stop_reg <= 1'b1;
                    end
                end
            end
            S_MUL1:  prod_reg <= {40'd0, 24'({3'd0, tips_reg} * tip_amt_reg)};
            S_MUL2:  prod_reg <= 64'(prod_reg[23:0] * 29'd360000000);
            S_RATEW:
            begin
                if (drsp.done)
                begin
                    rate_reg <= q_sat;
                end
            end
            default:
            begin
            end
        endcase
        if (fin_go)
        begin
            o_acc_reg   <= acc_reg;
            o_tips_reg  <= {3'd0, tips_reg};
            o_daily_reg <= daily_reg;
            o_int_reg   <= known_reg ? interval_reg : 32'd0;
            o_known_reg <= known_reg;
            o_rate_reg  <= rate_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = o_acc_reg;
    assign tips_in_window   = o_tips_reg;
    assign accumulated_tips = o_daily_reg;
    assign interval_ms      = o_int_reg;
    assign interval_valid   = o_known_reg;
    assign rate_x100        = o_rate_reg;

    `RTW_ASSERT_NEXT(a_accept_starts_roll, in_acc, state_reg == S_ROLL)
    `RTW_ASSERT(a_div_done_waited, drsp.done |-> (state_reg == S_ROLLW || state_reg == S_RATEW))
    `RTW_ASSERT_NEXT(a_fin_publishes, fin_go, out_valid_reg && state_reg == S_IDLE)
    `RTW_ASSERT(a_ring_contiguous, (state_reg == S_IDLE) |-> ((vld_vec & (vld_vec + 1'b1)) == '0))

endmodule

>>> test/tb_rain_tip_window_tracker.sv
`timescale 1ns / 1ps
module tb_rain_tip_window_tracker;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_RATE_WIN = 2'd1;
    localparam logic [1:0] REG_DAY_WIN  = 2'd2;
    localparam logic [1:0] REG_TIP_AMT  = 2'd3;
    localparam logic REQ_TIP   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam int   DEPTH     = 16;
    localparam int   SETTLE    = 300;
    localparam int   LIMIT     = 4000000;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  tips;
        logic [31:0] daily;
        logic [31:0] interval;
        logic        interval_ok;
        logic [31:0] rate;
    } gauge_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_QUERY;
    logic [63:0] now_us = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic [7:0]  tips_in_window;
    logic [31:0] accumulated_tips;
    logic [31:0] interval_ms;
    logic        interval_valid;
    logic [31:0] rate_x100;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [39:0] cfg_data = '0;

    rain_tip_window_tracker uut (.*);

    always #1 clk = ~clk;

    // gauge model state and register copy
    logic [31:0] debounce_q, rate_win_q;
    logic [39:0] day_win_q;
    logic [15:0] tip_amt_q;
    logic [63:0] day_start_q, last_tip_q;
    logic [31:0] daily_q, last_int_q;
    logic        int_known_q;
    logic [63:0] history_q [DEPTH];
    logic [3:0]  head_q;
    int          fill_q;

    gauge_status_t status_q[$];
    int            errors = 0;
    int            cycles = 0;
    int            stall_pct = 20;
    int            gap_pct = 40;
    logic          hold_out = 1'b0;
    logic [63:0]   clock_us = 64'd1000;

    function automatic void clear_tips();
        for (int i = 0; i < DEPTH; i++)
            history_q[i] = '0;
        head_q = '0;
        fill_q = 0;
        daily_q = '0;
        last_tip_q = '0;
        last_int_q = '0;
        int_known_q = 1'b0;
    endfunction

    function automatic logic [31:0] div_round_sat(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        q = (2 * num + den) / (2 * den);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic gauge_status_t predict_status(logic rt, logic [63:0] t);
        gauge_status_t s;
        logic [63:0] win, elapsed, delta, ms, ts;
        logic [3:0]  idx;
        int          n;
        s = '0;
        win = (day_win_q == 0) ? 64'd1 : {24'd0, day_win_q};
        if (day_start_q == 0)
            day_start_q = t;
        else
        begin
            elapsed = t - day_start_q;
            if (elapsed >= win)
            begin
                day_start_q += (elapsed / win) * win;
                clear_tips();
            end
        end
        if (rt == REQ_TIP)
        begin
            s.accepted = 1'b1;
            if (last_tip_q != 0)
            begin
                delta = t - last_tip_q;
                if (delta < {32'd0, debounce_q})
                    s.accepted = 1'b0;
                else
                begin
                    ms = delta / 64'd1000;
                    last_int_q = (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
                    int_known_q = 1'b1;
                end
            end
            else
            begin
                last_int_q = '0;
                int_known_q = 1'b0;
            end
            if (s.accepted)
            begin
                last_tip_q = t;
                daily_q++;
                history_q[head_q] = t;
                head_q++;
                if (fill_q < DEPTH)
                    fill_q++;
            end
        end
        n = 0;
        for (int i = 0; i < fill_q; i++)
        begin
            idx = head_q - 4'd1 - i[3:0];
            ts = history_q[idx];
            if (t >= ts)
            begin
                if (t - ts <= {32'd0, rate_win_q})
                    n++;
                else
                    break;
            end
        end
        s.tips = n[7:0];
        s.daily = daily_q;
        s.interval = int_known_q ? last_int_q : '0;
        s.interval_ok = int_known_q;
        if (n != 0)
        begin
            if (int_known_q && last_int_q > 0)
                s.rate = div_round_sat({48'd0, tip_amt_q} * 64'd360000, {32'd0, last_int_q});
            else if (rate_win_q != 0)
                s.rate = div_round_sat(64'(n) * {48'd0, tip_amt_q} * 64'd360000000,
                                       {32'd0, rate_win_q});
        end
        return s;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= hold_out || ($urandom_range(0, 99) < stall_pct);

    // predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin
        gauge_status_t got, want;
        if (rst_n && in_valid && !in_stall)
            status_q.push_back(predict_status(req_type, now_us));
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{accepted, tips_in_window, accumulated_tips, interval_ms,
                    interval_valid, rate_x100};
            if (status_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = status_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    task automatic idle_gap();
        int r, g;
        r = $urandom_range(0, 99);
        if (r >= gap_pct)
            g = 0;
        else if (r >= gap_pct / 8)
            g = $urandom_range(1, 3);
        else
            g = $urandom_range(20, 60);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_event(logic rt, logic [63:0] t);
        in_valid <= 1'b1;
        req_type <= rt;
        now_us <= t;
        do
            @(posedge clk);
        while (in_stall);
        idle_gap();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [39:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE: debounce_q = val[31:0];
            REG_RATE_WIN: rate_win_q = val[31:0];
            REG_DAY_WIN:  day_win_q = val;
            default:      tip_amt_q = val[15:0];
        endcase
    endtask

    task automatic configure(logic [31:0] db, logic [31:0] rw, logic [39:0] dw,
                             logic [15:0] amt);
        write_reg(REG_DEBOUNCE, {8'd0, db});
        write_reg(REG_RATE_WIN, {8'd0, rw});
        write_reg(REG_DAY_WIN, dw);
        write_reg(REG_TIP_AMT, {24'd0, amt});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly advance the gauge clock a little; sometimes jump, step back or go anywhere
    function automatic logic [63:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_us += $urandom_range(0, 20000);
        else if (r < 90)
            clock_us += $urandom_range(0, 3000000);
        else if (r < 96)
            clock_us += {$urandom, $urandom} >> $urandom_range(20, 63);
        else if (r < 98)
            clock_us -= $urandom_range(0, 50000);
        else
            clock_us = {$urandom, $urandom};
        return clock_us;
    endfunction

    function automatic logic rand_req();
        return ($urandom_range(0, 99) < 70) ? REQ_TIP : REQ_QUERY;
    endfunction

    task automatic test_directed();
        logic [63:0] t;
        send_event(REQ_QUERY, 64'd0);
        send_event(REQ_TIP, 64'd0);
        send_event(REQ_TIP, 64'd5000);
        send_event(REQ_TIP, 64'd8000);
        send_event(REQ_TIP, 64'd20000);
        send_event(REQ_QUERY, 64'd21000);
        send_event(REQ_TIP, 64'd15000);
        t = 64'd30000;
        for (int i = 0; i < 18; i++)
        begin
            t += 64'd12000;
            send_event(REQ_TIP, t);
        end
        send_event(REQ_QUERY, t + 64'd700000000);
        send_event(REQ_QUERY, t + 64'd90000000000);
        send_event(REQ_TIP, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();
    endtask

    task automatic test_register_extremes();
        configure(32'd0, 32'd1, 40'd1, 16'hFFFF);
        for (int i = 0; i < 60; i++)
            send_event(rand_req(), next_time());
        drain();
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'd1000000000000, 16'd0);
        for (int i = 0; i < 60; i++)
            send_event(rand_req(), next_time());
        drain();
        configure(32'd0, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 16'hFFFF);
        for (int i = 0; i < 60; i++)
            send_event(rand_req(), next_time());
        drain();
    endtask

    task automatic test_random_storms();
        for (int p = 0; p < 5; p++)
        begin
            configure($urandom_range(0, 5000), $urandom_range(1, 200000),
                      40'($urandom_range(1000000, 20000000)), 16'($urandom));
            stall_pct = (p == 2) ? 0 : 25;
            gap_pct = (p == 3) ? 0 : 40;
            for (int i = 0; i < 180; i++)
                send_event(rand_req(), next_time());
            drain();
        end
        stall_pct = 20;
        gap_pct = 40;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_out <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_out <= 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_event(rand_req(), next_time());
        join
        drain();
    endtask

    task automatic test_noise();
        for (int i = 0; i < 100; i++)
            send_event(rand_req(), {$urandom, $urandom});
        drain();
    endtask

    initial
    begin
        debounce_q = 32'd10000;
        rate_win_q = 32'd600000000;
        day_win_q = 40'd86400000000;
        tip_amt_q = 16'd279;
        day_start_q = '0;
        clear_tips();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_storms();
        test_backpressure();
        test_noise();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/rtw_pkg.sv
hw/rtl/rtw_cell.sv
hw/rtl/rtw_div.sv
hw/rtl/rain_tip_window_tracker.sv
test/tb_rain_tip_window_tracker.sv
